// ===== rtl/gpcf_pkg.sv =====
`timescale 1ns / 1ps

package gpcf_pkg;

    // Matrix dimensions.
    localparam int MAX_ROWS = 32;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int NROWS_W  = $clog2(MAX_ROWS + 1);
    localparam int NCOLS_W  = $clog2(MAX_COLS + 1);

    // Field and register widths.
    localparam int KIND_W     = 2;
    localparam int ROWS_CFG_W = 6;
    localparam int COLS_CFG_W = 7;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    // Register index, taken from paddr[2].
    localparam logic REG_ROWS_USED = 1'b0;
    localparam logic REG_COLS_USED = 1'b1;

    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = ROWS_CFG_W'(32);
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = COLS_CFG_W'(64);

    typedef logic [MAX_COLS-1:0] t_row;

    // Item kinds; the fourth code means nothing and is ignored.
    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_SET   = 2'd1,
        KIND_ELIM  = 2'd2,
        KIND_NOP   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SET_WR,
        S_PIV_CAP,
        S_PIV_ENC,
        S_ELIM,
        S_EMIT
    } t_state;

    // Index of the lowest set bit, zero for an empty row.
    function automatic logic [COL_W-1:0] lowest_set(input t_row v);
        logic [COL_W-1:0] idx;
        idx = '0;
        for (int c = MAX_COLS - 1; c >= 0; c--) begin
            if (v[c]) begin
                idx = COL_W'(c);
            end
        end
        return idx;
    endfunction

    // Ones in the columns below ncols.
    function automatic t_row col_mask(input logic [NCOLS_W-1:0] ncols);
        t_row m;
        for (int c = 0; c < MAX_COLS; c++) begin
            m[c] = (NCOLS_W'(c) < ncols);
        end
        return m;
    endfunction

endpackage

// ===== rtl/gpcf_if.sv =====
`timescale 1ns / 1ps

// Input item channel.
interface gpcf_in_if import gpcf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ROW_W-1:0]  row_index;
    logic [COL_W-1:0]  col_index;

    modport source (output valid, kind, row_index, col_index, input ready);
    modport sink (input valid, kind, row_index, col_index, output ready);
endinterface

// Result channel.
interface gpcf_out_if import gpcf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] pivot_col;
    logic             has_pivot;
    logic             last;

    modport source (output valid, out_row, pivot_col, has_pivot, last, input ready);
    modport sink (input valid, out_row, pivot_col, has_pivot, last, output ready);
endinterface

// ===== rtl/gf2_pivot_column_finder.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Contents
// ----------+-----------+---------------------------------------------------
// i_item    | in        | kind, row_index, col_index (valid/ready)
// o_res     | out       | out_row, pivot_col, has_pivot, last (valid/ready)
// APB       | in/out    | rows_used at 0x0, cols_used at 0x4
//
// A set reads the row, then writes it back; a clear, a set outside the matrix
// in use and an unused kind complete in the cycle they are taken.
// An elimination, for N rows in use, reads each pivot row and encodes it,
// then all N rows stream through the single read port and single write port
// of the row memory, then its result is issued once the output register is free.
// Reset is synchronous; per-row valid bits make the memory read as all zeros.
// Input is refused while an item is at work; a full output register stalls
// only the issue of the next result.

module gf2_pivot_column_finder import gpcf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gpcf_in_if.sink               i_item,
    gpcf_out_if.source            o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Configuration registers.
    logic [ROWS_CFG_W-1:0] r_rows_used;
    logic [COLS_CFG_W-1:0] r_cols_used;
    logic [NROWS_W-1:0]    nrows;
    logic [NCOLS_W-1:0]    ncols;
    t_row                  mask;

    // Control state.
    t_state           r_state, n_state;
    logic [ROW_W-1:0] r_i, n_i;
    logic [ROW_W-1:0] r_j, n_j;
    t_row             r_cur, n_cur;
    logic [COL_W-1:0] r_pcol, n_pcol;
    logic             r_has, n_has;
    logic [ROW_W-1:0] r_set_row, n_set_row;
    logic [COL_W-1:0] r_set_col, n_set_col;

    // Row memory.
    t_row              r_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_vld;
    t_row              r_rd;
    logic              r_rd_vld;
    t_row              rd_data;
    logic              rd_en;
    logic [ROW_W-1:0]  rd_addr;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_addr;
    t_row              wr_data;
    logic              clr_all;

    // Output register.
    logic             r_o_valid;
    logic [ROW_W-1:0] r_o_row;
    logic [COL_W-1:0] r_o_pcol;
    logic             r_o_has;
    logic             r_o_last;
    logic             out_load;
    logic             i_last, j_last;

    // APB writes; pready is always high.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_used <= ROWS_RESET;
            r_cols_used <= COLS_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_ROWS_USED) begin
                r_rows_used <= pwdata[ROWS_CFG_W-1:0];
            end else begin
                r_cols_used <= pwdata[COLS_CFG_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_COLS_USED) begin
            prdata = APB_DATA_W'(r_cols_used);
        end else begin
            prdata = APB_DATA_W'(r_rows_used);
        end
    end

    // Clamp the register values to between one and the matrix size.
    always_comb begin
        if (r_rows_used == '0) begin
            nrows = NROWS_W'(1);
        end else if (r_rows_used > MAX_ROWS) begin
            nrows = NROWS_W'(MAX_ROWS);
        end else begin
            nrows = NROWS_W'(r_rows_used);
        end
        if (r_cols_used == '0) begin
            ncols = NCOLS_W'(1);
        end else if (r_cols_used > MAX_COLS) begin
            ncols = NCOLS_W'(MAX_COLS);
        end else begin
            ncols = NCOLS_W'(r_cols_used);
        end
    end

    assign mask   = col_mask(ncols);
    assign i_last = (NROWS_W'(r_i) + NROWS_W'(1)) == nrows;
    assign j_last = (NROWS_W'(r_j) + NROWS_W'(1)) == nrows;

    // Memory with one read and one write port. The walk never reads the row
    // that is written in the same cycle, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd     <= r_mem[rd_addr];
            r_rd_vld <= r_vld[rd_addr];
        end
    end

    // A row never written since reset or clear reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr_all) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = r_rd_vld ? r_rd : '0;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_i       <= n_i;
        r_j       <= n_j;
        r_cur     <= n_cur;
        r_pcol    <= n_pcol;
        r_has     <= n_has;
        r_set_row <= n_set_row;
        r_set_col <= n_set_col;
    end

    // Sequencer: next state, memory accesses and result issue.
    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_cur     = r_cur;
        n_pcol    = r_pcol;
        n_has     = r_has;
        n_set_row = r_set_row;
        n_set_col = r_set_col;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = '0;
        clr_all   = 1'b0;
        out_load  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    case (i_item.kind)
                        KIND_CLEAR: begin
                            clr_all = 1'b1;
                        end
                        KIND_SET: begin
                            if (NROWS_W'(i_item.row_index) < nrows &&
                                NCOLS_W'(i_item.col_index) < ncols) begin
                                rd_en     = 1'b1;
                                rd_addr   = i_item.row_index;
                                n_set_row = i_item.row_index;
                                n_set_col = i_item.col_index;
                                n_state   = S_SET_WR;
                            end
                        end
                        KIND_ELIM: begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_i     = '0;
                            n_state = S_PIV_CAP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SET_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_set_row;
                wr_data = rd_data | (t_row'(1) << r_set_col);
                n_state = S_IDLE;
            end
            S_PIV_CAP: begin
                n_cur   = rd_data & mask;
                n_state = S_PIV_ENC;
            end
            S_PIV_ENC: begin
                n_pcol  = lowest_set(r_cur);
                n_has   = |r_cur;
                rd_en   = 1'b1;
                rd_addr = '0;
                n_j     = '0;
                n_state = S_ELIM;
            end
            S_ELIM: begin
                // Every row in use is masked and written back; the others
                // with the pivot column set also take the pivot row.
                wr_en   = 1'b1;
                wr_addr = r_j;
                if (r_j != r_i && rd_data[r_pcol]) begin
                    wr_data = (rd_data & mask) ^ r_cur;
                end else begin
                    wr_data = rd_data & mask;
                end
                if (j_last) begin
                    n_state = S_EMIT;
                end else begin
                    n_j     = r_j + ROW_W'(1);
                    rd_en   = 1'b1;
                    rd_addr = r_j + ROW_W'(1);
                end
            end
            S_EMIT: begin
                if (!r_o_valid || o_res.ready) begin
                    out_load = 1'b1;
                    if (i_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + ROW_W'(1);
                        rd_en   = 1'b1;
                        rd_addr = r_i + ROW_W'(1);
                        n_state = S_PIV_CAP;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_item.ready = (r_state == S_IDLE);

    // Output register: holds one result until its transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
        if (out_load) begin
            r_o_row  <= r_i;
            r_o_pcol <= r_has ? r_pcol : '0;
            r_o_has  <= r_has;
            r_o_last <= i_last;
        end
    end

    assign o_res.valid     = r_o_valid;
    assign o_res.out_row   = r_o_row;
    assign o_res.pivot_col = r_o_pcol;
    assign o_res.has_pivot = r_o_has;
    assign o_res.last      = r_o_last;

endmodule

// ===== rtl/gpcf_checker.sv =====
`timescale 1ns / 1ps

module gpcf_checker import gpcf_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [KIND_W-1:0] i_in_kind,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [ROW_W-1:0]  i_out_row,
    input logic [COL_W-1:0]  i_out_pcol,
    input logic              i_out_has,
    input logic              i_out_last
);

    // A waiting result holds its contents until taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_row) &&
        $stable(i_out_pcol) && $stable(i_out_has) && $stable(i_out_last))
        else $error("result changed while stalled");

    // An elimination keeps the input closed in the following cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_kind == KIND_ELIM |=> !i_in_ready)
        else $error("input open right after an elimination transaction");

    // Clears and unused kinds finish in the cycle they are taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_kind == KIND_CLEAR || i_in_kind == KIND_NOP)
        |=> i_in_ready)
        else $error("input closed after a single-cycle transaction");

    // While a result that is not the last is shown, the walk is still running.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input open before the last result");

    // An empty row reports column zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_has |-> i_out_pcol == '0)
        else $error("pivot column set on a row without pivot");

endmodule

bind gf2_pivot_column_finder gpcf_checker u_gpcf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_kind   (i_item.kind),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_row   (o_res.out_row),
    .i_out_pcol  (o_res.pivot_col),
    .i_out_has   (o_res.has_pivot),
    .i_out_last  (o_res.last)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import gpcf_pkg::*;

    // Kind code that the block has no meaning for and must ignore.
    localparam logic [KIND_W-1:0] KIND_UNUSED = KIND_NOP;

    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 200;

    typedef struct packed {
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] pivot_col;
        logic             has_pivot;
        logic             last;
    } t_pivot_res;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    gpcf_in_if  item_if ();
    gpcf_out_if res_if ();

    gf2_pivot_column_finder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the matrix store and the two registers.
    t_row                  shadow_rows [MAX_ROWS];
    logic [ROWS_CFG_W-1:0] rows_cfg;
    logic [COLS_CFG_W-1:0] cols_cfg;
    t_pivot_res            pending_pivots [$];

    int  fail_count  = 0;
    int  n_items     = 0;
    int  n_elims     = 0;
    int  n_results   = 0;
    int  n_cfg       = 0;
    int  burst_left  = 0;
    int  idle_cycles = 0;
    bit  rx_hold_req = 1'b0;

    always #2 i_clk = ~i_clk;

    // Effective row count after clamping the register to the legal range.
    function automatic int rows_in_use();
        if (rows_cfg == 0) return 1;
        if (rows_cfg > MAX_ROWS) return MAX_ROWS;
        return int'(rows_cfg);
    endfunction

    function automatic int cols_in_use();
        if (cols_cfg == 0) return 1;
        if (cols_cfg > MAX_COLS) return MAX_COLS;
        return int'(cols_cfg);
    endfunction

    // Apply one accepted item to the shadow matrix and queue the pivots it reports.
    task automatic predict_pivots(input logic [KIND_W-1:0] kind,
                                  input logic [ROW_W-1:0] row,
                                  input logic [COL_W-1:0] col);
        int         nr;
        int         nc;
        int         p;
        t_row       cur;
        t_pivot_res res;
        nr = rows_in_use();
        nc = cols_in_use();
        case (kind)
            KIND_CLEAR: begin
                foreach (shadow_rows[i]) shadow_rows[i] = '0;
            end
            KIND_SET: begin
                if (int'(row) < nr && int'(col) < nc) shadow_rows[row][col] = 1'b1;
            end
            KIND_ELIM: begin
                n_elims++;
                // Columns past the used width never take part.
                for (int i = 0; i < nr; i++) begin
                    for (int c = nc; c < MAX_COLS; c++) shadow_rows[i][c] = 1'b0;
                end
                for (int i = 0; i < nr; i++) begin
                    cur = shadow_rows[i];
                    res.out_row = ROW_W'(i);
                    res.last = (i == nr - 1);
                    if (cur == '0) begin
                        res.pivot_col = '0;
                        res.has_pivot = 1'b0;
                    end else begin
                        p = 0;
                        while (!cur[p]) p++;
                        for (int j = 0; j < nr; j++) begin
                            if (j != i && shadow_rows[j][p]) shadow_rows[j] ^= cur;
                        end
                        res.pivot_col = COL_W'(p);
                        res.has_pivot = 1'b1;
                    end
                    pending_pivots = {pending_pivots, res};
                end
            end
            default: begin
            end
        endcase
    endtask

    // Offer one item, idling first when the current burst is used up.
    task automatic send_item(input logic [KIND_W-1:0] kind,
                             input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 8);
            item_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_if.valid     = 1'b1;
        item_if.kind      = kind;
        item_if.row_index = row;
        item_if.col_index = col;
        do @(posedge i_clk); while (!item_if.ready);
        predict_pivots(kind, row, col);
        n_items++;
        burst_left--;
        @(negedge i_clk);
    endtask

    // Two-phase register write; the register takes the value on the access cycle.
    task automatic write_reg(input logic reg_sel, input logic [APB_DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_sel, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_sel == REG_ROWS_USED) rows_cfg = value[ROWS_CFG_W-1:0];
        else cols_cfg = value[COLS_CFG_W-1:0];
        n_cfg++;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Let every expected pivot drain, then give the block time to finish any set.
    task automatic wait_idle();
        item_if.valid = 1'b0;
        while (pending_pivots.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_dims(input int nrows, input int ncols);
        wait_idle();
        write_reg(REG_ROWS_USED, nrows);
        write_reg(REG_COLS_USED, ncols);
    endtask

    // Empty matrix, duplicate sets, the ignored kind, re-elimination and clear.
    task automatic test_directed_ops();
        send_item(KIND_ELIM, 5'd0, 6'd0);
        send_item(KIND_SET, 5'd0, 6'd0);
        send_item(KIND_SET, 5'd0, 6'd0);
        send_item(KIND_SET, 5'd31, 6'd63);
        send_item(KIND_SET, 5'd1, 6'd0);
        send_item(KIND_SET, 5'd1, 6'd5);
        send_item(KIND_SET, 5'd2, 6'd5);
        send_item(KIND_UNUSED, 5'd2, 6'd6);
        send_item(KIND_ELIM, 5'd0, 6'd0);
        send_item(KIND_ELIM, 5'd31, 6'd63);
        send_item(KIND_CLEAR, 5'd31, 6'd63);
        send_item(KIND_SET, 5'd30, 6'd63);
        send_item(KIND_ELIM, 5'd0, 6'd0);
    endtask

    // Narrowed matrix, entries outside it, and register values out of range.
    task automatic test_register_edges();
        send_item(KIND_SET, 5'd0, 6'd62);
        send_item(KIND_SET, 5'd0, 6'd3);
        send_item(KIND_SET, 5'd2, 6'd40);
        set_dims(3, 4);
        send_item(KIND_SET, 5'd1, 6'd10);
        send_item(KIND_SET, 5'd5, 6'd1);
        send_item(KIND_SET, 5'd1, 6'd3);
        send_item(KIND_ELIM, 5'd0, 6'd0);
        set_dims(0, 0);
        send_item(KIND_SET, 5'd0, 6'd0);
        send_item(KIND_ELIM, 5'd0, 6'd0);
        set_dims(63, 127);
        send_item(KIND_SET, 5'd31, 6'd63);
        send_item(KIND_ELIM, 5'd0, 6'd0);
    endtask

    // Load-then-eliminate sequences with random content under varied dimensions.
    task automatic test_random_sequences();
        int done_items;
        int phase;
        int phase_items;
        int nr;
        int nc;
        int nsets;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        done_items = 0;
        phase = 0;
        while (done_items < RANDOM_ITEMS) begin
            case (phase)
                0: set_dims(32, 64);
                1: set_dims(1, 1);
                2: set_dims(2, 127);
                3: set_dims(63, 0);
                4: set_dims(0, 64);
                default: set_dims($urandom_range(0, 63), $urandom_range(0, 127));
            endcase
            nr = rows_in_use();
            nc = cols_in_use();
            phase_items = 0;
            while (phase_items < 40 && done_items + phase_items < RANDOM_ITEMS) begin
                if ($urandom_range(0, 2) == 0) begin
                    send_item(KIND_CLEAR, 5'($urandom), 6'($urandom));
                    phase_items++;
                end
                nsets = $urandom_range(1, 10);
                repeat (nsets) begin
                    case ($urandom_range(0, 15))
                        0: begin
                            send_item(KIND_UNUSED, 5'($urandom), 6'($urandom));
                        end
                        1, 2: begin
                            send_item(KIND_SET, 5'($urandom), 6'($urandom));
                            phase_items++;
                        end
                        default: begin
                            row = ROW_W'($urandom_range(0, nr - 1));
                            // Crowd low columns half the time so rows share pivots.
                            if ($urandom_range(0, 1) == 0)
                                col = COL_W'($urandom_range(0, (nc < 8) ? nc - 1 : 7));
                            else
                                col = COL_W'($urandom_range(0, nc - 1));
                            send_item(KIND_SET, row, col);
                            phase_items++;
                        end
                    endcase
                end
                if ($urandom_range(0, 7) != 0) begin
                    send_item(KIND_ELIM, 5'($urandom), 6'($urandom));
                    phase_items++;
                    if ($urandom_range(0, 5) == 0) begin
                        send_item(KIND_ELIM, 5'($urandom), 6'($urandom));
                        phase_items++;
                    end
                end
            end
            done_items += phase_items;
            phase++;
        end
    endtask

    // Receiver holds off for a long stretch while items keep coming.
    task automatic test_output_backpressure();
        set_dims(12, 64);
        @(posedge i_clk);
        rx_hold_req = 1'b1;
        @(negedge i_clk);
        for (int i = 0; i < 8; i++)
            send_item(KIND_SET, ROW_W'($urandom_range(0, 11)), COL_W'($urandom_range(0, 15)));
        send_item(KIND_ELIM, 5'd0, 6'd0);
        for (int i = 0; i < 4; i++)
            send_item(KIND_SET, ROW_W'($urandom_range(0, 11)), COL_W'($urandom_range(0, 63)));
        send_item(KIND_ELIM, 5'd0, 6'd0);
        wait_idle();
        rx_hold_req = 1'b0;
    endtask

    // Receiver: a long hold when asked for, otherwise a rotating stall pattern.
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    logic [15:0] rx_pattern = '1;
    int          rx_phase = 0;

    always @(negedge i_clk) begin
        if (rx_hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (!rx_hold_req) hold_done = 1'b0;
        if (rx_phase == 0) begin
            if ($urandom_range(0, 3) == 0) rx_pattern = '1;
            else rx_pattern = 16'($urandom) | (16'd1 << $urandom_range(0, 15));
        end
        rx_phase = (rx_phase + 1) % 16;
        if (hold_left > 0) begin
            res_if.ready = 1'b0;
            hold_left--;
        end else begin
            res_if.ready = rx_pattern[rx_phase];
        end
    end

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Each result transaction is checked against the oldest expected pivot.
    t_pivot_res want_res;

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_pivots.size() == 0) begin
                $error("out_row: expected no result, actual %0d", res_if.out_row);
                fail_count++;
            end else begin
                want_res = pending_pivots.pop_front();
                n_results++;
                compare_field("out_row", want_res.out_row, res_if.out_row);
                compare_field("pivot_col", want_res.pivot_col, res_if.pivot_col);
                compare_field("has_pivot", want_res.has_pivot, res_if.has_pivot);
                compare_field("last", want_res.last, res_if.last);
            end
        end
    end

    // Watchdog: too many cycles without any transaction on either channel.
    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("gf2_pivot_column_finder: mismatch");
            $finish;
        end
    end

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        item_if.valid     = 1'b0;
        item_if.kind      = KIND_CLEAR;
        item_if.row_index = '0;
        item_if.col_index = '0;
        res_if.ready      = 1'b0;
        rows_cfg          = ROWS_RESET;
        cols_cfg          = COLS_RESET;
        foreach (shadow_rows[i]) shadow_rows[i] = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_ops();
        test_register_edges();
        test_random_sequences();
        test_output_backpressure();
        wait_idle();

        $display("Sent %0d items (%0d eliminations) over %0d register writes.",
                 n_items, n_elims, n_cfg);
        $display("Checked %0d pivot results, including a long receiver hold.", n_results);
        if (fail_count == 0)
            $display("gf2_pivot_column_finder: match");
        else
            $display("gf2_pivot_column_finder: mismatch");
        $finish;
    end

endmodule
